// File: hw/rtl/svpwm_pkg.sv
package svpwm_pkg;

   localparam int NUM_PHASES = 3;

   // sqrt(3)/2 in q16, held as an unsigned 17-bit multiplier operand
   localparam int SQRT3_BITS = 17;
   localparam logic [SQRT3_BITS-1:0] SQRT3_HALF_Q16 = 17'd56756;

   // fraction bits of the offset phase voltage relative to the bus voltage
   localparam int NORM_FRAC = 17;

   typedef struct packed {
      logic [NUM_PHASES-1:0] neg;
      logic [NUM_PHASES-1:0] ovf;
      logic                  zero;
   } flags_type;

endpackage

// File: hw/rtl/svpwm_phase.sv
module svpwm_phase import svpwm_pkg::*; #(
   parameter int VOLT_BITS = 16,
   localparam int PW = VOLT_BITS + 18,
   localparam int NW = VOLT_BITS + 20,
   localparam int DW = VOLT_BITS + NORM_FRAC
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [VOLT_BITS-1:0]                v_alpha,
   input  logic [VOLT_BITS-1:0]                v_beta,
   input  logic [VOLT_BITS-1:0]                v_dc,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [NUM_PHASES-1:0][NW-1:0]       mag,
   output logic [DW-1:0]                       den,
   output flags_type                           flags
);

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic e1, e2, e3, e4, e5;

   // stage 1: sqrt3/2 * beta
   logic signed [PW-1:0]        kb_ff, kb_in;
   logic signed [VOLT_BITS-1:0] alpha1_ff;
   logic [VOLT_BITS-1:0]        vdc1_ff;
   // stage 2: inverse clarke
   logic signed [PW-1:0]        ph2_ff [NUM_PHASES];
   logic signed [PW-1:0]        ph2_in [NUM_PHASES];
   logic [VOLT_BITS-1:0]        vdc2_ff;
   // stage 3: min and max
   logic signed [PW-1:0]        ph3_ff [NUM_PHASES];
   logic signed [PW-1:0]        vmax_ff, vmax_in, vmin_ff, vmin_in;
   logic [VOLT_BITS-1:0]        vdc3_ff;
   // stage 4: zero-sequence offset
   logic signed [NW-1:0]        n4_ff [NUM_PHASES];
   logic signed [NW-1:0]        n4_in [NUM_PHASES];
   logic [VOLT_BITS-1:0]        vdc4_ff;
   // stage 5: magnitude and range check
   logic [NUM_PHASES-1:0][NW-1:0] mag_ff, mag_in;
   logic [DW-1:0]               den_ff, den_in;
   flags_type                   flags_ff, flags_in;

   assign e5 = !v5_ff || out_ready;
   assign e4 = !v4_ff || e5;
   assign e3 = !v3_ff || e4;
   assign e2 = !v2_ff || e3;
   assign e1 = !v1_ff || e2;
   assign in_ready = e1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (e1) v1_ff <= in_valid;
         if (e2) v2_ff <= v1_ff;
         if (e3) v3_ff <= v2_ff;
         if (e4) v4_ff <= v3_ff;
         if (e5) v5_ff <= v4_ff;
      end
   end

   always_comb begin
      kb_in = PW'($signed(v_beta) * $signed({1'b0, SQRT3_HALF_Q16}));
   end

   always_comb begin
      logic signed [PW-1:0] ah;
      logic signed [PW-1:0] va;
      ah = PW'(alpha1_ff) <<< 15;
      va = PW'(alpha1_ff) <<< 16;
      ph2_in[0] = va;
      ph2_in[1] = kb_ff - ah;
      ph2_in[2] = -kb_ff - ah;
   end

   always_comb begin
      vmin_in = ph2_ff[0];
      if (ph2_ff[1] < vmin_in) vmin_in = ph2_ff[1];
      if (ph2_ff[2] < vmin_in) vmin_in = ph2_ff[2];
      vmax_in = ph2_ff[0];
      if (ph2_ff[1] > vmax_in) vmax_in = ph2_ff[1];
      if (ph2_ff[2] > vmax_in) vmax_in = ph2_ff[2];
   end

   always_comb begin
      for (int i = 0; i < NUM_PHASES; i++) begin
         n4_in[i] = (NW'(ph3_ff[i]) <<< 1) - NW'(vmax_ff) - NW'(vmin_ff);
      end
   end

   always_comb begin
      den_in = {vdc4_ff, {NORM_FRAC{1'b0}}};
      flags_in.zero = (vdc4_ff == '0);
      for (int i = 0; i < NUM_PHASES; i++) begin
         flags_in.neg[i] = n4_ff[i][NW-1];
         mag_in[i] = flags_in.neg[i] ? NW'(-n4_ff[i]) : NW'(n4_ff[i]);
         flags_in.ovf[i] = (mag_in[i] >= NW'(den_in));
      end
   end

   always_ff @(posedge clock) begin
      if (e1 && in_valid) begin
         kb_ff     <= kb_in;
         alpha1_ff <= $signed(v_alpha);
         vdc1_ff   <= v_dc;
      end
      if (e2 && v1_ff) begin
         ph2_ff  <= ph2_in;
         vdc2_ff <= vdc1_ff;
      end
      if (e3 && v2_ff) begin
         ph3_ff  <= ph2_ff;
         vmax_ff <= vmax_in;
         vmin_ff <= vmin_in;
         vdc3_ff <= vdc2_ff;
      end
      if (e4 && v3_ff) begin
         n4_ff   <= n4_in;
         vdc4_ff <= vdc3_ff;
      end
      if (e5 && v4_ff) begin
         mag_ff   <= mag_in;
         den_ff   <= den_in;
         flags_ff <= flags_in;
      end
   end

   assign out_valid = v5_ff;
   assign mag       = mag_ff;
   assign den       = den_ff;
   assign flags     = flags_ff;

endmodule

// File: hw/rtl/svpwm_div_stage.sv
module svpwm_div_stage import svpwm_pkg::*; #(
   parameter int VOLT_BITS = 16,
   parameter int DUTY_BITS = 16,
   localparam int DW = VOLT_BITS + NORM_FRAC,
   localparam int QW = DUTY_BITS + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [NUM_PHASES-1:0][DW-1:0] in_rem,
   input  logic [NUM_PHASES-1:0][QW-1:0] in_quo,
   input  logic [DW-1:0]                 in_den,
   input  flags_type                     in_flags,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [NUM_PHASES-1:0][DW-1:0] out_rem,
   output logic [NUM_PHASES-1:0][QW-1:0] out_quo,
   output logic [DW-1:0]                 out_den,
   output flags_type                     out_flags
);

   logic                          valid_ff;
   logic                          enable;
   logic [NUM_PHASES-1:0][DW-1:0] rem_ff, rem_in;
   logic [NUM_PHASES-1:0][QW-1:0] quo_ff, quo_in;
   logic [DW-1:0]                 den_ff;
   flags_type                     flags_ff;

   assign enable   = !valid_ff || out_ready;
   assign in_ready = enable;

   // one restoring division step per phase
   always_comb begin
      for (int i = 0; i < NUM_PHASES; i++) begin
         logic [DW:0] r2;
         logic [DW:0] diff;
         r2   = {in_rem[i], 1'b0};
         diff = r2 - {1'b0, in_den};
         if (r2 >= {1'b0, in_den}) begin
            rem_in[i] = diff[DW-1:0];
            quo_in[i] = {in_quo[i][QW-2:0], 1'b1};
         end else begin
            rem_in[i] = r2[DW-1:0];
            quo_in[i] = {in_quo[i][QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && in_valid) begin
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
         den_ff   <= in_den;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_den   = den_ff;
   assign out_flags = flags_ff;

endmodule

// File: hw/rtl/svpwm_sat.sv
module svpwm_sat import svpwm_pkg::*; #(
   parameter int DUTY_BITS = 16,
   localparam int QW = DUTY_BITS + 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [NUM_PHASES-1:0][QW-1:0]        in_quo,
   input  flags_type                            in_flags,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [NUM_PHASES-1:0][DUTY_BITS-1:0] duty,
   output logic                                 clipped
);

   localparam logic [QW-1:0]        HALF     = QW'(1) << (DUTY_BITS - 1);
   localparam logic [QW-1:0]        TOP      = {1'b0, {DUTY_BITS{1'b1}}};
   localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};
   localparam logic [DUTY_BITS-1:0] DUTY_MID = DUTY_BITS'(HALF);

   logic                                 valid_ff;
   logic                                 enable;
   logic [NUM_PHASES-1:0][DUTY_BITS-1:0] duty_ff, duty_in;
   logic                                 clipped_ff, clipped_in;

   assign enable   = !valid_ff || out_ready;
   assign in_ready = enable;

   always_comb begin
      clipped_in = 1'b0;
      for (int i = 0; i < NUM_PHASES; i++) begin
         logic [QW:0]   rnd;
         logic [QW-1:0] dev;
         logic [QW-1:0] up;
         logic [QW-1:0] dn;
         rnd = {1'b0, in_quo[i]} + (QW+1)'(1);
         dev = rnd[QW:1];
         up  = HALF + dev;
         dn  = HALF - dev;
         if (in_flags.zero) begin
            duty_in[i] = DUTY_MID;
            clipped_in = 1'b1;
         end else if (in_flags.neg[i]) begin
            if (in_flags.ovf[i] || dev > HALF) begin
               duty_in[i] = '0;
               clipped_in = 1'b1;
            end else begin
               duty_in[i] = dn[DUTY_BITS-1:0];
            end
         end else begin
            if (in_flags.ovf[i] || up > TOP) begin
               duty_in[i] = DUTY_MAX;
               clipped_in = 1'b1;
            end else begin
               duty_in[i] = up[DUTY_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && in_valid) begin
         duty_ff    <= duty_in;
         clipped_ff <= clipped_in;
      end
   end

   assign out_valid = valid_ff;
   assign duty      = duty_ff;
   assign clipped   = clipped_ff;

endmodule

// File: hw/rtl/svpwm_duty_generator.sv
// svpwm duty generator, min-max zero-sequence injection
// stages: five phase stages, one divider stage per quotient bit, one saturation stage
// throughput: one transfer per cycle unless rsp_tready stalls the output;
//   every stage has its own valid and fills bubbles
// reset: synchronous, active high, empties every stage; data registers are not reset
module svpwm_duty_generator import svpwm_pkg::*; #(
   parameter int VOLT_BITS = 16,
   parameter int DUTY_BITS = 16,
   localparam int IDW = ((3 * VOLT_BITS + 7) / 8) * 8,
   localparam int ODW = ((3 * DUTY_BITS + 7) / 8) * 8
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [IDW-1:0] req_tdata,   // v_alpha, v_beta, v_dc
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [ODW-1:0] rsp_tdata,   // duty_a, duty_b, duty_c
   output logic [0:0]     rsp_tuser    // clipped
);

   localparam int NW = VOLT_BITS + 20;
   localparam int DW = VOLT_BITS + NORM_FRAC;
   localparam int QW = DUTY_BITS + 1;
   localparam int DS = DUTY_BITS + 1;

   logic [NUM_PHASES-1:0][NW-1:0]        mag;
   logic [NUM_PHASES-1:0][DUTY_BITS-1:0] duty;
   logic                                 clipped;

   logic [DS:0]                          vld;
   logic [DS:0]                          rdy;
   logic [NUM_PHASES-1:0][DW-1:0]        rem [DS+1];
   logic [NUM_PHASES-1:0][QW-1:0]        quo [DS+1];
   logic [DW-1:0]                        den [DS+1];
   flags_type                            flg [DS+1];

   svpwm_phase #(
      .VOLT_BITS(VOLT_BITS)
   ) u_phase (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .v_alpha   (req_tdata[VOLT_BITS-1:0]),
      .v_beta    (req_tdata[2*VOLT_BITS-1:VOLT_BITS]),
      .v_dc      (req_tdata[3*VOLT_BITS-1:2*VOLT_BITS]),
      .out_valid (vld[0]),
      .out_ready (rdy[0]),
      .mag       (mag),
      .den       (den[0]),
      .flags     (flg[0])
   );

   // remainder starts as the magnitude; it only matters when below the divisor
   always_comb begin
      for (int i = 0; i < NUM_PHASES; i++) begin
         rem[0][i] = mag[i][DW-1:0];
         quo[0][i] = '0;
      end
   end

   for (genvar k = 0; k < DS; k++) begin : g_div
      svpwm_div_stage #(
         .VOLT_BITS(VOLT_BITS),
         .DUTY_BITS(DUTY_BITS)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[k]),
         .in_ready  (rdy[k]),
         .in_rem    (rem[k]),
         .in_quo    (quo[k]),
         .in_den    (den[k]),
         .in_flags  (flg[k]),
         .out_valid (vld[k+1]),
         .out_ready (rdy[k+1]),
         .out_rem   (rem[k+1]),
         .out_quo   (quo[k+1]),
         .out_den   (den[k+1]),
         .out_flags (flg[k+1])
      );
   end

   svpwm_sat #(
      .DUTY_BITS(DUTY_BITS)
   ) u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld[DS]),
      .in_ready  (rdy[DS]),
      .in_quo    (quo[DS]),
      .in_flags  (flg[DS]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .duty      (duty),
      .clipped   (clipped)
   );

   assign rsp_tdata = ODW'({duty[2], duty[1], duty[0]});
   assign rsp_tuser = clipped;

endmodule

// File: sim/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import svpwm_pkg::*;

   localparam int VOLT_W = 16;
   localparam int DUTY_W = 16;
   localparam int LATENCY = DUTY_W + 7;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 540;
   localparam int MAX_PRINTS = 40;
   localparam longint HALF_DUTY = longint'(1) << (DUTY_W - 1);
   localparam longint FULL_DUTY = (longint'(1) << DUTY_W) - 1;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_a;
      logic [DUTY_W-1:0] duty_b;
      logic [DUTY_W-1:0] duty_c;
      logic              clipped;
   } duty_set_type;

   class duty_scoreboard;
      duty_set_type expected_duties[$];
      int mismatches;
      int checked;
      int clipped_seen;
      int zero_bus_seen;

      function new();
         mismatches = 0;
         checked = 0;
         clipped_seen = 0;
         zero_bus_seen = 0;
      endfunction

      task report(string msg);
         if (mismatches < MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
         end
         mismatches++;
      endtask

      // offset phase voltage over bus, rounded half away from zero, then saturated
      function logic [DUTY_W-1:0] scaled_duty(longint n, longint den, inout logic clip);
         longint mag;
         longint rem;
         longint quot;
         longint dev;
         logic   neg;
         neg = n < 0;
         mag = neg ? -n : n;
         if (mag >= den) begin
            clip = 1'b1;
            return neg ? '0 : FULL_DUTY[DUTY_W-1:0];
         end
         rem = mag;
         quot = 0;
         for (int i = 0; i < DUTY_W + 1; i++) begin
            rem = rem << 1;
            quot = quot << 1;
            if (rem >= den) begin
               rem = rem - den;
               quot = quot | 1;
            end
         end
         dev = (quot + 1) >> 1;
         if (neg) begin
            if (dev > HALF_DUTY) begin
               clip = 1'b1;
               return '0;
            end
            return DUTY_W'(HALF_DUTY - dev);
         end
         if (HALF_DUTY + dev > FULL_DUTY) begin
            clip = 1'b1;
            return FULL_DUTY[DUTY_W-1:0];
         end
         return DUTY_W'(HALF_DUTY + dev);
      endfunction

      function duty_set_type compute_duties(logic [VOLT_W-1:0] alpha_raw,
                                            logic [VOLT_W-1:0] beta_raw,
                                            logic [VOLT_W-1:0] vdc);
         duty_set_type d;
         longint alpha;
         longint beta;
         longint va;
         longint vb;
         longint vc;
         longint lo;
         longint hi;
         longint mid2;
         longint den;
         logic   clip;
         alpha = longint'($signed(alpha_raw));
         beta = longint'($signed(beta_raw));
         if (vdc == 0) begin
            d.duty_a = HALF_DUTY[DUTY_W-1:0];
            d.duty_b = HALF_DUTY[DUTY_W-1:0];
            d.duty_c = HALF_DUTY[DUTY_W-1:0];
            d.clipped = 1'b1;
            return d;
         end
         // inverse clarke with 16 fraction bits
         va = alpha * 65536;
         vb = -alpha * 32768 + longint'(SQRT3_HALF_Q16) * beta;
         vc = -alpha * 32768 - longint'(SQRT3_HALF_Q16) * beta;
         lo = va;
         if (vb < lo) lo = vb;
         if (vc < lo) lo = vc;
         hi = va;
         if (vb > hi) hi = vb;
         if (vc > hi) hi = vc;
         mid2 = hi + lo;
         den = longint'(vdc) << NORM_FRAC;
         clip = 1'b0;
         d.duty_a = scaled_duty(2 * va - mid2, den, clip);
         d.duty_b = scaled_duty(2 * vb - mid2, den, clip);
         d.duty_c = scaled_duty(2 * vc - mid2, den, clip);
         d.clipped = clip;
         return d;
      endfunction

      function void note_command(logic [VOLT_W-1:0] alpha, logic [VOLT_W-1:0] beta,
                                 logic [VOLT_W-1:0] vdc);
         expected_duties.push_back(compute_duties(alpha, beta, vdc));
         if (vdc == 0) zero_bus_seen++;
      endfunction

      task check_duties(duty_set_type got);
         duty_set_type want;
         if (expected_duties.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
         end
         want = expected_duties.pop_front();
         checked++;
         if (want.clipped) clipped_seen++;
         if (got.duty_a !== want.duty_a)
            report($sformatf("result %0d duty_a %h, want %h", checked, got.duty_a, want.duty_a));
         if (got.duty_b !== want.duty_b)
            report($sformatf("result %0d duty_b %h, want %h", checked, got.duty_b, want.duty_b));
         if (got.duty_c !== want.duty_c)
            report($sformatf("result %0d duty_c %h, want %h", checked, got.duty_c, want.duty_c));
         if (got.clipped !== want.clipped)
            report($sformatf("result %0d clipped %b, want %b", checked, got.clipped,
                             want.clipped));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [3*VOLT_W-1:0]   req_tdata = '0;   // v_alpha, v_beta, v_dc
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [3*DUTY_W-1:0]   rsp_tdata;        // duty_a, duty_b, duty_c
   logic [0:0]            rsp_tuser;        // clipped

   duty_scoreboard board;
   int tx_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit pressure_on = 1'b0;
   int quiet_cycles = 0;
   int sent = 0;

   svpwm_duty_generator #(
      .VOLT_BITS(VOLT_W),
      .DUTY_BITS(DUTY_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side: check each transfer, then choose ready for the next edge
   initial begin : receiver
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            board.check_duties({rsp_tdata[DUTY_W-1:0], rsp_tdata[2*DUTY_W-1:DUTY_W],
                                rsp_tdata[3*DUTY_W-1:2*DUTY_W], rsp_tuser[0]});
         end
         if (pressure_on && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   task automatic send_duties(input logic [VOLT_W-1:0] alpha, input logic [VOLT_W-1:0] beta,
                              input logic [VOLT_W-1:0] vdc);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {vdc, beta, alpha};
      do @(posedge clock); while (!req_tready);
      board.note_command(alpha, beta, vdc);
      sent++;
   endtask

   // mostly scaled vectors with a bus near the saturation boundary, some raw noise, zero and tiny buses
   task automatic send_random_duties();
      int mode;
      int shift;
      int mag_a;
      int mag_b;
      int peak;
      logic [VOLT_W-1:0] alpha;
      logic [VOLT_W-1:0] beta;
      logic [VOLT_W-1:0] vdc;
      mode = $urandom_range(15);
      alpha = VOLT_W'($urandom);
      beta = VOLT_W'($urandom);
      vdc = VOLT_W'($urandom);
      if (mode == 4) begin
         vdc = '0;
      end else if (mode == 5) begin
         vdc = VOLT_W'($urandom_range(1, 8));
      end else if (mode > 5) begin
         shift = $urandom_range(VOLT_W - 1);
         alpha = $signed(alpha) >>> shift;
         beta = $signed(beta) >>> shift;
         mag_a = $signed(alpha);
         mag_b = $signed(beta);
         if (mag_a < 0) mag_a = -mag_a;
         if (mag_b < 0) mag_b = -mag_b;
         peak = (mag_a > mag_b) ? mag_a : mag_b;
         if (peak < 16) begin
            vdc = VOLT_W'($urandom_range(1, 40));
         end else begin
            vdc = VOLT_W'($urandom_range(peak / 2, (2 * peak > 65535) ? 65535 : 2 * peak));
         end
      end
      send_duties(alpha, beta, vdc);
   endtask

   initial begin : stimulus
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, zero bus, exact and past saturation on both sides
      send_duties(16'h0000, 16'h0000, 16'h0001);
      send_duties(16'h0000, 16'h0000, 16'h0000);
      send_duties(16'h7fff, 16'h1234, 16'h0000);
      send_duties(16'h8000, 16'h8000, 16'h0000);
      send_duties(16'h7fff, 16'h0000, 16'hffff);
      send_duties(16'h8000, 16'h0000, 16'hffff);
      send_duties(16'h0000, 16'h7fff, 16'hffff);
      send_duties(16'h0000, 16'h8000, 16'hffff);
      send_duties(16'h7fff, 16'h7fff, 16'hffff);
      send_duties(16'h8000, 16'h8000, 16'hffff);
      send_duties(16'h7fff, 16'h8000, 16'h0001);
      send_duties(16'h8000, 16'h7fff, 16'h0001);
      send_duties(16'h0002, 16'h0000, 16'h0003);
      send_duties(16'hfffe, 16'h0000, 16'h0003);
      send_duties(16'h0004, 16'h0000, 16'h0003);
      send_duties(16'hfffc, 16'h0000, 16'h0003);
      send_duties(16'h0001, 16'h0000, 16'h0002);
      send_duties(16'h0001, 16'h0001, 16'hffff);
      send_duties(16'hffff, 16'hffff, 16'hffff);
      send_duties(16'h0064, 16'hffc7, 16'h00c8);
      send_duties(16'h7fff, 16'h0000, 16'h7fff);
      send_duties(16'h5555, 16'haaaa, 16'h8000);

      tx_idle_pct = 35;
      rsp_idle_pct = 71;
      repeat (PHASE_ITEMS) send_random_duties();
      tx_idle_pct = 71;
      rsp_idle_pct = 35;
      repeat (PHASE_ITEMS) send_random_duties();
      tx_idle_pct = 0;
      rsp_idle_pct = 0;
      pressure_on = 1'b1;
      repeat (PHASE_ITEMS + 20) send_random_duties();
      req_tvalid <= 1'b0;

      while (board.expected_duties.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);

      $display("sent %0d vectors, checked %0d results: %0d saturated, %0d with zero bus",
               sent, board.checked, board.clipped_seen, board.zero_bus_seen);
      $display("idle mixes on both sides plus a %0d-cycle output hold-off", HOLD_CYCLES);
      if (board.mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/svpwm_pkg.sv
hw/rtl/svpwm_phase.sv
hw/rtl/svpwm_div_stage.sv
hw/rtl/svpwm_sat.sv
hw/rtl/svpwm_duty_generator.sv
sim/testbench.sv
